// ----- sv/tcli_pkg.sv -----
// Shared constants, codes and types for the text coordinate line indexer.
`default_nettype none

package tcli_pkg;

   // Dimension table and counters
   localparam int MAX_DIMS = 16;
   localparam int IDX_W    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int CNT_W    = $clog2(MAX_DIMS + 2);

   // Data path widths
   localparam int WORD_W      = 64;
   localparam int CHAR_W      = 8;
   localparam int STATUS_W    = 3;
   localparam int MUL_DIGIT_W = 16;
   localparam int MUL_STEPS   = WORD_W / MUL_DIGIT_W;
   localparam int MUL_STEP_W  = (MUL_STEPS > 1) ? $clog2(MUL_STEPS) : 1;
   localparam int MUL_PP_W    = WORD_W + MUL_DIGIT_W;

   // Character codes
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_CR      = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'd57;

   localparam logic [WORD_W-1:0] DECIMAL_BASE = 64'd10;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_MALFORMED = 3'd1,
      STATUS_TOO_MANY  = 3'd2,
      STATUS_END_VALID = 3'd3,
      STATUS_END_OTHER = 3'd4
   } status_type;

   // Request to the checked multiply-add unit: a * b + addend
   typedef struct packed {
      logic              start;
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] addend;
   } mul_req_type;

   // Status from the multiply-add unit
   typedef struct packed {
      logic done;
      logic overflow;
   } mul_status_type;

endpackage

`default_nettype wire

// ----- sv/tcli_mul.sv -----
// Checked 64-bit multiply-add unit, one 16-bit digit of b per cycle.
`default_nettype none

module tcli_mul
   import tcli_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire mul_req_type    mul_req,
   output logic [WORD_W-1:0]   mul_result,
   output mul_status_type      mul_status
);

   logic                  busy_ff;
   logic                  done_ff;
   logic [MUL_STEP_W-1:0] step_ff;
   logic [WORD_W-1:0]     a_ff;
   logic [WORD_W-1:0]     b_ff;
   logic [WORD_W-1:0]     c_ff;
   logic [WORD_W-1:0]     acc_ff;
   logic                  ovf_ff;

   logic                   last_step;
   logic [MUL_DIGIT_W-1:0] digit;
   logic [MUL_PP_W-1:0]    partial;
   logic [MUL_PP_W-1:0]    shifted;
   logic [MUL_PP_W-1:0]    addend_ext;
   logic [MUL_PP_W:0]      sum;
   logic                   step_ovf;

   // Horner step: acc = acc * 2^16 + a * digit, addend joins on the last step
   always_comb begin
      last_step  = (step_ff == MUL_STEP_W'(MUL_STEPS - 1));
      digit      = b_ff[WORD_W-1 -: MUL_DIGIT_W];
      partial    = MUL_PP_W'(a_ff) * MUL_PP_W'(digit);
      shifted    = {{MUL_DIGIT_W{1'b0}}, acc_ff[WORD_W-MUL_DIGIT_W-1:0],
                    {MUL_DIGIT_W{1'b0}}};
      addend_ext = last_step ? MUL_PP_W'(c_ff) : '0;
      sum        = {1'b0, shifted} + {1'b0, partial} + {1'b0, addend_ext};
      step_ovf   = (|acc_ff[WORD_W-1 -: MUL_DIGIT_W]) | (|sum[MUL_PP_W:WORD_W]);
   end

   // Sequence control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + MUL_STEP_W'(1);
            if (last_step) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operands and accumulator
   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         a_ff   <= mul_req.a;
         b_ff   <= mul_req.b;
         c_ff   <= mul_req.addend;
         acc_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (busy_ff) begin
         acc_ff <= sum[WORD_W-1:0];
         ovf_ff <= ovf_ff | step_ovf;
         b_ff   <= b_ff << MUL_DIGIT_W;
      end
   end

   assign mul_result          = acc_ff;
   assign mul_status.done     = done_ff;
   assign mul_status.overflow = ovf_ff;

   // Checks
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> !busy_ff)
      else $error("multiply started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("done without a finished run");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff || $past(mul_req.start))
      else $error("done held longer than one cycle");

endmodule

`default_nettype wire

// ----- sv/text_coordinate_line_indexer_core.sv -----
// Top level of the text coordinate line indexer: sequencer, dimension table, result register.
//
// Usage: text bytes enter on the req_ channel, one per transfer, tagged by
// req_kind as dimension-line (0) or coordinate-line (1) bytes; the tag of a
// line's first byte governs the line. req_end_of_input marks the end of input.
// A newline or end of input yields one transfer on the rsp_ channel with a
// status, a 64-bit value and the product overflow flag; other bytes yield none.
// Timing: one item is in work at a time; req_stall is high until it is done.
// A separator byte passes through dispatch and finish, the first digit of a
// number through dispatch alone, and each further digit also waits on the x10
// step, run through the shared checked multiply-add unit (four 16-bit digit
// steps plus load and handoff). Closing a number adds at most one product for a
// dimension, or up to two products, a table read and a compare for a coordinate.
// When no number is open, a newline goes from dispatch to finish, which loads the
// result register. Reset (synchronous) clears all line state; the dimension table is not
// cleared and only entries written since are read. A stalled result holds in
// the output register; the next item is taken meanwhile, and only an item that
// itself produces a result waits until the register frees up.
`default_nettype none

module text_coordinate_line_indexer_core
   import tcli_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Input channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_kind,
   input  wire logic [CHAR_W-1:0]    req_char_code,
   input  wire logic                 req_end_of_input,
   // Result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic [WORD_W-1:0]         rsp_value,
   output logic                      rsp_product_overflow
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_DISPATCH = 7'b0000010,
      S_CLOSE    = 7'b0000100,
      S_STRIDE   = 7'b0001000,
      S_CHECK    = 7'b0010000,
      S_MUL      = 7'b0100000,
      S_FINISH   = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      MOP_DIGIT  = 2'd0,
      MOP_PROD   = 2'd1,
      MOP_STRIDE = 2'd2,
      MOP_INDEX  = 2'd3
   } mul_op_type;

   // Sequencer and current item
   state_type         state_ff, state_in;
   mul_op_type        mop_ff, mop_in;
   logic              kind_ff, kind_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic              eoi_ff, eoi_in;
   logic [WORD_W-1:0] x_ff, x_in;

   // Line state
   logic              line_kind_ff, line_kind_in;
   logic              started_ff, started_in;
   logic              valid_ff, valid_in;
   logic              open_ff, open_in;
   logic [WORD_W-1:0] nv_ff, nv_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] prod_ff, prod_in;
   logic              povf_ff, povf_in;
   logic              toomany_ff, toomany_in;
   logic [WORD_W-1:0] pf_ff, pf_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [WORD_W-1:0] li_ff, li_in;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_povf_ff, rsp_povf_in;
   logic              rsp_load;

   // Dimension table
   logic [WORD_W-1:0] dim_table [MAX_DIMS];
   logic [WORD_W-1:0] rd_ff;
   logic [IDX_W-1:0]  rd_addr;
   logic [CNT_W-1:0]  pos_minus2;
   logic              tbl_we;

   // Multiply-add unit
   mul_req_type       mul_req;
   mul_status_type    mul_status;
   logic [WORD_W-1:0] mul_result;

   logic              is_digit;
   logic              is_space;
   logic              out_free;
   logic [WORD_W-1:0] digit_val;

   tcli_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .mul_req    (mul_req),
      .mul_result (mul_result),
      .mul_status (mul_status)
   );

   // Decode the held byte
   always_comb begin
      is_digit  = !eoi_ff && (char_ff >= CHAR_ZERO) && (char_ff <= CHAR_NINE);
      is_space  = (char_ff == CHAR_SPACE) ||
                  ((char_ff >= CHAR_TAB) && (char_ff <= CHAR_CR));
      digit_val = WORD_W'(char_ff - CHAR_ZERO);
      out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // Table read address: entry 0 for the first coordinate, else pos - 2
   always_comb begin
      pos_minus2 = pos_ff - CNT_W'(2);
      if ((state_ff == S_CLOSE) && (pos_ff == CNT_W'(1))) begin
         rd_addr = '0;
      end else begin
         rd_addr = pos_minus2[IDX_W-1:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      mop_in        = mop_ff;
      kind_in       = kind_ff;
      char_in       = char_ff;
      eoi_in        = eoi_ff;
      x_in          = x_ff;
      line_kind_in  = line_kind_ff;
      started_in    = started_ff;
      valid_in      = valid_ff;
      open_in       = open_ff;
      nv_in         = nv_ff;
      count_in      = count_ff;
      prod_in       = prod_ff;
      povf_in       = povf_ff;
      toomany_in    = toomany_ff;
      pf_in         = pf_ff;
      pos_in        = pos_ff;
      li_in         = li_ff;
      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_povf_in   = rsp_povf_ff;
      tbl_we        = 1'b0;
      mul_req       = '0;

      unique case (state_ff)
         // Take a transfer and open a line on its first byte
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               char_in  = req_char_code;
               eoi_in   = req_end_of_input;
               state_in = S_DISPATCH;
               if (!started_ff) begin
                  line_kind_in = req_kind;
                  started_in   = 1'b1;
                  valid_in     = 1'b1;
                  open_in      = 1'b0;
                  nv_in        = '0;
                  if (!req_kind) begin
                     count_in   = '0;
                     prod_in    = WORD_W'(1);
                     povf_in    = 1'b0;
                     toomany_in = 1'b0;
                  end else begin
                     pf_in  = WORD_W'(1);
                     pos_in = CNT_W'(1);
                     li_in  = '0;
                  end
               end
            end
         end

         // Accumulate a digit, close the open number, or pass any other byte to finish
         S_DISPATCH: begin
            if (is_digit) begin
               if (!open_ff) begin
                  nv_in    = digit_val;
                  open_in  = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  mul_req.start  = 1'b1;
                  mul_req.a      = nv_ff;
                  mul_req.b      = DECIMAL_BASE;
                  mul_req.addend = digit_val;
                  mop_in         = MOP_DIGIT;
                  state_in       = S_MUL;
               end
            end else if (open_ff) begin
               state_in = S_CLOSE;
            end else begin
               state_in = S_FINISH;
            end
         end

         // Close the number as a dimension or a coordinate
         S_CLOSE: begin
            x_in    = nv_ff;
            nv_in   = '0;
            open_in = 1'b0;
            state_in = S_FINISH;
            if (nv_ff == '0) begin
               valid_in = 1'b0;
            end else if (valid_ff) begin
               if (!line_kind_ff) begin
                  if (count_ff < CNT_W'(MAX_DIMS)) begin
                     tbl_we   = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                     if (!povf_ff) begin
                        mul_req.start = 1'b1;
                        mul_req.a     = prod_ff;
                        mul_req.b     = nv_ff;
                        mop_in        = MOP_PROD;
                        state_in      = S_MUL;
                     end
                  end else begin
                     toomany_in = 1'b1;
                     valid_in   = 1'b0;
                  end
               end else if (pos_ff > count_ff) begin
                  valid_in = 1'b0;
               end else if (pos_ff > CNT_W'(1)) begin
                  state_in = S_STRIDE;
               end else begin
                  pos_in   = pos_ff + CNT_W'(1);
                  state_in = S_CHECK;
               end
            end
         end

         // Grow the stride by the previous dimension
         S_STRIDE: begin
            mul_req.start = 1'b1;
            mul_req.a     = pf_ff;
            mul_req.b     = rd_ff;
            mop_in        = MOP_STRIDE;
            pos_in        = pos_ff + CNT_W'(1);
            state_in      = S_MUL;
         end

         // Bound-check the coordinate, then add (x - 1) * stride
         S_CHECK: begin
            if (x_ff > rd_ff) begin
               valid_in = 1'b0;
               state_in = S_FINISH;
            end else begin
               mul_req.start  = 1'b1;
               mul_req.a      = x_ff - WORD_W'(1);
               mul_req.b      = pf_ff;
               mul_req.addend = li_ff;
               mop_in         = MOP_INDEX;
               state_in       = S_MUL;
            end
         end

         // Wait for the multiply-add unit and apply its result
         S_MUL: begin
            if (mul_status.done) begin
               case (mop_ff)
                  MOP_DIGIT: begin
                     if (mul_status.overflow) begin
                        valid_in = 1'b0;
                     end else begin
                        nv_in = mul_result;
                     end
                     state_in = S_IDLE;
                  end
                  MOP_PROD: begin
                     if (mul_status.overflow) begin
                        povf_in = 1'b1;
                     end else begin
                        prod_in = mul_result;
                     end
                     state_in = S_FINISH;
                  end
                  MOP_STRIDE: begin
                     if (mul_status.overflow) begin
                        valid_in = 1'b0;
                        state_in = S_FINISH;
                     end else begin
                        pf_in    = mul_result;
                        state_in = S_CHECK;
                     end
                  end
                  default: begin
                     if (mul_status.overflow) begin
                        valid_in = 1'b0;
                     end else begin
                        li_in = mul_result;
                     end
                     state_in = S_FINISH;
                  end
               endcase
            end
         end

         // End the line or the input, or check a separator
         S_FINISH: begin
            if (eoi_ff) begin
               if (out_free) begin
                  rsp_load      = 1'b1;
                  rsp_status_in = (!line_kind_ff && valid_ff && (count_ff != '0)) ?
                                  STATUS_END_VALID : STATUS_END_OTHER;
                  rsp_value_in  = '0;
                  rsp_povf_in   = 1'b0;
                  line_kind_in  = 1'b0;
                  started_in    = 1'b0;
                  valid_in      = 1'b1;
                  open_in       = 1'b0;
                  nv_in         = '0;
                  count_in      = '0;
                  prod_in       = WORD_W'(1);
                  povf_in       = 1'b0;
                  toomany_in    = 1'b0;
                  pf_in         = WORD_W'(1);
                  pos_in        = CNT_W'(1);
                  li_in         = '0;
                  state_in      = S_IDLE;
               end
            end else if (char_ff == CHAR_NEWLINE) begin
               if (out_free) begin
                  rsp_load     = 1'b1;
                  rsp_value_in = '0;
                  rsp_povf_in  = 1'b0;
                  if (!line_kind_ff) begin
                     if (toomany_ff) begin
                        rsp_status_in = STATUS_TOO_MANY;
                     end else if (!valid_ff) begin
                        rsp_status_in = STATUS_MALFORMED;
                     end else begin
                        rsp_status_in = STATUS_OK;
                        rsp_value_in  = povf_ff ? '0 : prod_ff;
                        rsp_povf_in   = povf_ff;
                     end
                  end else if (valid_ff && (pos_ff > count_ff)) begin
                     rsp_status_in = STATUS_OK;
                     rsp_value_in  = li_ff;
                  end else begin
                     rsp_status_in = STATUS_MALFORMED;
                  end
                  started_in = 1'b0;
                  state_in   = S_IDLE;
               end
            end else begin
               if (!is_space) begin
                  valid_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold the result until the receiver takes it
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and line state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         line_kind_ff <= 1'b0;
         started_ff   <= 1'b0;
         valid_ff     <= 1'b1;
         open_ff      <= 1'b0;
         nv_ff        <= '0;
         count_ff     <= '0;
         prod_ff      <= WORD_W'(1);
         povf_ff      <= 1'b0;
         toomany_ff   <= 1'b0;
         pf_ff        <= WORD_W'(1);
         pos_ff       <= CNT_W'(1);
         li_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         line_kind_ff <= line_kind_in;
         started_ff   <= started_in;
         valid_ff     <= valid_in;
         open_ff      <= open_in;
         nv_ff        <= nv_in;
         count_ff     <= count_in;
         prod_ff      <= prod_in;
         povf_ff      <= povf_in;
         toomany_ff   <= toomany_in;
         pf_ff        <= pf_in;
         pos_ff       <= pos_in;
         li_ff        <= li_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and result payload registers
   always_ff @(posedge clock) begin
      mop_ff        <= mop_in;
      kind_ff       <= kind_in;
      char_ff       <= char_in;
      eoi_ff        <= eoi_in;
      x_ff          <= x_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_povf_ff   <= rsp_povf_in;
   end

   // Dimension table: write on a stored dimension, registered read
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         dim_table[count_ff[IDX_W-1:0]] <= nv_ff;
      end
      rd_ff <= dim_table[rd_addr];
   end

   assign req_stall            = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_value            = rsp_value_ff;
   assign rsp_product_overflow = rsp_povf_ff;

   // Checks
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_status.done |-> state_ff == S_MUL)
      else $error("multiply result arrived outside the wait state");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      started_ff && line_kind_ff |-> pos_ff <= count_ff + CNT_W'(1))
      else $error("coordinate position ran past the dimension count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_DIMS))
      else $error("dimension count exceeds the table depth");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH))
      else $error("result raised outside the finish state");

   a_povf_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_povf_ff |-> rsp_status_ff == STATUS_OK)
      else $error("product overflow flagged on a failed line");

endmodule

`default_nettype wire

// ----- tb/sv/text_coordinate_line_indexer_core_test.sv -----
// Self-checking testbench for the text coordinate line indexer: directed and random text lines.
`timescale 1ns / 100ps

module text_coordinate_line_indexer_core_test;
   import tcli_pkg::*;

   localparam logic KIND_DIM   = 1'b0;
   localparam logic KIND_COORD = 1'b1;
   localparam logic [CHAR_W-1:0] CHAR_VTAB     = 8'd11;
   localparam logic [CHAR_W-1:0] CHAR_FORMFEED = 8'd12;
   localparam logic [WORD_W-1:0] WORD_MAX      = '1;
   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 40;
   localparam int RANDOM_ITEMS = 840;

   typedef struct {
      status_type        status;
      logic [WORD_W-1:0] value;
      logic              product_overflow;
   } line_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_kind = 1'b0;
   logic [CHAR_W-1:0]   req_char_code = '0;
   logic                req_end_of_input = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [WORD_W-1:0]   rsp_value;
   logic                rsp_product_overflow;

   text_coordinate_line_indexer_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_char_code        (req_char_code),
      .req_end_of_input     (req_end_of_input),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_value            (rsp_value),
      .rsp_product_overflow (rsp_product_overflow)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Line indexer state as the block should hold it
   logic [WORD_W-1:0] dim_table [MAX_DIMS];
   logic [CNT_W-1:0]  dim_count;
   logic [WORD_W-1:0] dim_product;
   logic              dim_product_ovf;
   logic [WORD_W-1:0] digits_value;
   logic              digits_open;
   logic              line_ok;
   logic              too_many_dims;
   logic              line_open;
   logic [WORD_W-1:0] stride;
   logic [CNT_W-1:0]  coord_pos;
   logic [WORD_W-1:0] coord_index;
   logic              line_is_coord;

   line_result_type   expected_lines[$];
   int                mismatch_count = 0;
   int                idle_cycles = 0;

   // Stimulus state
   logic [WORD_W-1:0] gen_dims[$];
   logic              first_of_line = 1'b1;
   logic              send_idle_on = 1'b0;
   logic              rsp_idle_on = 1'b0;
   int                rsp_stall_left = 0;
   int                sent_items = 0;

   function automatic void clear_indexer();
      dim_count       = '0;
      dim_product     = 1;
      dim_product_ovf = 1'b0;
      digits_value    = '0;
      digits_open     = 1'b0;
      line_ok         = 1'b1;
      too_many_dims   = 1'b0;
      line_open       = 1'b0;
      stride          = 1;
      coord_pos       = 1;
      coord_index     = '0;
      line_is_coord   = 1'b0;
   endfunction

   // Return 1 when a * b fits in one word
   function automatic logic mul_checked(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                                        output logic [WORD_W-1:0] prod);
      logic [2*WORD_W-1:0] full;
      full = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
      prod = full[WORD_W-1:0];
      return full[2*WORD_W-1:WORD_W] == '0;
   endfunction

   function automatic void open_line(input logic kind);
      line_is_coord = kind;
      line_open     = 1'b1;
      line_ok       = 1'b1;
      digits_open   = 1'b0;
      digits_value  = '0;
      if (kind == KIND_DIM) begin
         dim_count       = '0;
         dim_product     = 1;
         dim_product_ovf = 1'b0;
         too_many_dims   = 1'b0;
      end else begin
         stride      = 1;
         coord_pos   = 1;
         coord_index = '0;
      end
   endfunction

   function automatic void push_digit(input logic [WORD_W-1:0] d);
      if (!digits_open) begin
         digits_value = d;
         digits_open  = 1'b1;
      end else if (digits_value <= WORD_MAX / DECIMAL_BASE) begin
         digits_value = digits_value * DECIMAL_BASE;
         if (digits_value <= WORD_MAX - d) begin
            digits_value = digits_value + d;
         end else begin
            line_ok = 1'b0;
         end
      end else begin
         line_ok = 1'b0;
      end
   endfunction

   function automatic void store_dim(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] p;
      if (dim_count < MAX_DIMS) begin
         dim_table[IDX_W'(dim_count)] = x;
         dim_count++;
         if (!dim_product_ovf) begin
            if (mul_checked(dim_product, x, p)) begin
               dim_product = p;
            end else begin
               dim_product_ovf = 1'b1;
            end
         end
      end else begin
         too_many_dims = 1'b1;
         line_ok       = 1'b0;
      end
   endfunction

   // Fold one one-based coordinate into the linear index
   function automatic void add_coord(input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] t;
      logic [WORD_W:0]   s;
      if (coord_pos > dim_count) begin
         line_ok = 1'b0;
         return;
      end
      if (coord_pos > 1) begin
         if (!mul_checked(stride, dim_table[IDX_W'(coord_pos - 2)], t)) begin
            coord_pos++;
            line_ok = 1'b0;
            return;
         end
         coord_pos++;
         stride = t;
      end else begin
         coord_pos++;
      end
      if (x > dim_table[IDX_W'(coord_pos - 2)]) begin
         line_ok = 1'b0;
         return;
      end
      if (!mul_checked(x - 1, stride, t)) begin
         line_ok = 1'b0;
         return;
      end
      s = {1'b0, t} + {1'b0, coord_index};
      if (s[WORD_W]) begin
         line_ok = 1'b0;
         return;
      end
      coord_index = s[WORD_W-1:0];
   endfunction

   function automatic void close_digits();
      logic [WORD_W-1:0] x;
      x            = digits_value;
      digits_open  = 1'b0;
      digits_value = '0;
      if (x == '0) line_ok = 1'b0;
      if (!line_ok) return;
      if (line_is_coord == KIND_DIM) begin
         store_dim(x);
      end else begin
         add_coord(x);
      end
   endfunction

   // Advance the indexer by one byte; report a line result when one is due
   function automatic void index_line_byte(input logic kind, input logic [CHAR_W-1:0] code,
                                           input logic eoi, output logic has_result,
                                           output line_result_type res);
      has_result           = 1'b0;
      res.status           = STATUS_OK;
      res.value            = '0;
      res.product_overflow = 1'b0;
      if (!line_open) open_line(kind);
      if (eoi) begin
         if (digits_open) close_digits();
         has_result = 1'b1;
         if (line_is_coord == KIND_DIM && line_ok && dim_count >= 1) begin
            res.status = STATUS_END_VALID;
         end else begin
            res.status = STATUS_END_OTHER;
         end
         clear_indexer();
         return;
      end
      if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
         push_digit(WORD_W'(code - CHAR_ZERO));
         return;
      end
      if (digits_open) close_digits();
      if (code == CHAR_NEWLINE) begin
         has_result = 1'b1;
         if (line_is_coord == KIND_DIM) begin
            if (too_many_dims) begin
               res.status = STATUS_TOO_MANY;
            end else if (!line_ok) begin
               res.status = STATUS_MALFORMED;
            end else begin
               res.value            = dim_product_ovf ? '0 : dim_product;
               res.product_overflow = dim_product_ovf;
            end
         end else begin
            if (coord_pos < dim_count + 1) line_ok = 1'b0;
            if (line_ok) begin
               res.value = coord_index;
            end else begin
               res.status = STATUS_MALFORMED;
            end
         end
         line_open = 1'b0;
         return;
      end
      if (!(code == CHAR_SPACE || (code >= CHAR_TAB && code <= CHAR_CR))) line_ok = 1'b0;
   endfunction

   // Predict on each input transfer, check each result transfer, watch for a hang
   always @(posedge clock) begin : score_results
      logic            got;
      line_result_type res;
      line_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            index_line_byte(req_kind, req_char_code, req_end_of_input, got, res);
            if (got) expected_lines.push_back(res);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_lines.size() == 0) begin
               $error("result transfer with no line result pending: status %0d value %0d",
                      rsp_status, rsp_value);
               mismatch_count++;
            end else begin
               want = expected_lines.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_value !== want.value) begin
                  $error("value: expected %0d, actual %0d", want.value, rsp_value);
                  mismatch_count++;
               end
               if (rsp_product_overflow !== want.product_overflow) begin
                  $error("product_overflow: expected %0d, actual %0d",
                         want.product_overflow, rsp_product_overflow);
                  mismatch_count++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Result side: random stall runs, mostly short, a few long
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall      <= 1'b1;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
         rsp_stall      <= 1'b1;
         rsp_stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                       : $urandom_range(10, 40);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic int pick_send_gap();
      int r;
      if (!send_idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Drive one byte and hold it until the transfer
   task automatic send_byte(input logic kind, input logic [CHAR_W-1:0] code, input logic eoi);
      int gap;
      gap = pick_send_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_char_code    <= code;
      req_end_of_input <= eoi;
      do @(posedge clock); while (req_stall);
      sent_items++;
   endtask

   // Hold off the sender until every line result has come back
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_lines.size() != 0) @(negedge clock);
   endtask

   // The first byte of a line carries the line tag; the rest carry a random one
   task automatic send_char(input logic kind, input logic [CHAR_W-1:0] code);
      logic k;
      k = first_of_line ? kind : 1'($urandom_range(0, 1));
      first_of_line = (code == CHAR_NEWLINE);
      send_byte(k, code, 1'b0);
   endtask

   task automatic send_text(input logic kind, input string text);
      int i;
      for (i = 0; i < text.len(); i++) send_char(kind, text[i]);
   endtask

   task automatic send_end(input logic kind);
      send_byte(kind, CHAR_W'($urandom_range(0, 255)), 1'b1);
      first_of_line = 1'b1;
      gen_dims.delete();
   endtask

   task automatic send_blanks(input logic kind, input int least);
      int n;
      int r;
      n = $urandom_range(least, least + 2);
      repeat (n) begin
         r = $urandom_range(0, 9);
         if (r < 6)       send_char(kind, CHAR_SPACE);
         else if (r == 6) send_char(kind, CHAR_TAB);
         else if (r == 7) send_char(kind, CHAR_CR);
         else if (r == 8) send_char(kind, CHAR_VTAB);
         else             send_char(kind, CHAR_FORMFEED);
      end
   endtask

   // Send a value in decimal, now and then with leading zeros
   task automatic send_number(input logic kind, input logic [WORD_W-1:0] value);
      logic [CHAR_W-1:0] digits[$];
      logic [WORD_W-1:0] rest;
      int                i;
      rest = value;
      do begin
         digits.push_front(CHAR_ZERO + CHAR_W'(rest % DECIMAL_BASE));
         rest = rest / DECIMAL_BASE;
      end while (rest != 0);
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 2)) send_char(kind, CHAR_ZERO);
      for (i = 0; i < digits.size(); i++) send_char(kind, digits[i]);
   endtask

   function automatic logic [WORD_W-1:0] pick_dim();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3)  return '0;
      if (r < 70) return WORD_W'($urandom_range(1, 9));
      if (r < 88) return WORD_W'($urandom_range(10, 5000));
      if (r < 96) return rand_word();
      return 64'd1 << $urandom_range(16, 63);
   endfunction

   task automatic send_random_dims(input logic terminate);
      int                count;
      int                i;
      logic [WORD_W-1:0] v;
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(7, MAX_DIMS + 2)
                                          : $urandom_range(0, 6);
      gen_dims.delete();
      if ($urandom_range(0, 3) == 0) send_blanks(KIND_DIM, 1);
      for (i = 0; i < count; i++) begin
         v = pick_dim();
         if (i > 0) send_blanks(KIND_DIM, 1);
         send_number(KIND_DIM, v);
         if (v != 0 && gen_dims.size() < MAX_DIMS) gen_dims.push_back(v);
      end
      if ($urandom_range(0, 29) == 0) send_char(KIND_DIM, CHAR_W'($urandom_range(0, 255)));
      if (terminate) send_char(KIND_DIM, CHAR_NEWLINE);
   endtask

   // Mostly in-range coordinates; some lines short, long or with one bad value
   task automatic send_random_coords();
      int                count;
      int                bad;
      int                i;
      logic [WORD_W-1:0] limit;
      logic [WORD_W-1:0] x;
      count = gen_dims.size();
      case ($urandom_range(0, 11))
         0: if (count > 0) count--;
         1: count++;
         default: ;
      endcase
      bad = ($urandom_range(0, 11) == 0) ? $urandom_range(0, count) : -1;
      if ($urandom_range(0, 3) == 0) send_blanks(KIND_COORD, 1);
      for (i = 0; i < count; i++) begin
         limit = (i < gen_dims.size()) ? gen_dims[i] : 64'd3;
         if (i == bad) begin
            x = ($urandom_range(0, 1) == 0) ? '0 : limit + 1;
         end else if (limit <= 1) begin
            x = 1;
         end else begin
            x = rand_word() % limit + 1;
         end
         if (i > 0) send_blanks(KIND_COORD, 1);
         send_number(KIND_COORD, x);
      end
      if ($urandom_range(0, 24) == 0) send_char(KIND_COORD, CHAR_W'($urandom_range(0, 255)));
      send_char(KIND_COORD, CHAR_NEWLINE);
   endtask

   task automatic send_noise_line();
      int   n;
      logic kind;
      n    = $urandom_range(1, 8);
      kind = 1'($urandom_range(0, 1));
      repeat (n) send_char(kind, CHAR_W'($urandom_range(0, 255)));
      send_char(kind, CHAR_NEWLINE);
   endtask

   // Plain lines: empty lines, dimensions, coordinates, whitespace, out-of-range and zero coordinates
   task automatic test_basic_lines();
      send_idle_on = 1'b0;
      rsp_idle_on  = 1'b0;
      send_text(KIND_COORD, "\n");
      send_text(KIND_COORD, "1\n");
      send_text(KIND_DIM, "\n");
      send_text(KIND_DIM, "3 4\t5\n");
      send_text(KIND_COORD, "2 3 4\n");
      send_text(KIND_COORD, "3 4 5\n");
      send_text(KIND_COORD, "1 1\n");
      send_text(KIND_COORD, "1 1 1 1\n");
      send_text(KIND_COORD, "4 1 1\n");
      send_text(KIND_COORD, "0 1 1\n");
      send_char(KIND_DIM, CHAR_CR);
      send_char(KIND_DIM, CHAR_VTAB);
      send_text(KIND_DIM, "7");
      send_char(KIND_DIM, CHAR_FORMFEED);
      send_text(KIND_DIM, "08 \n");
      wait_for_results();
   endtask

   // Number, product, stride and index overflow; zero and too many dimensions
   task automatic test_overflow();
      send_idle_on = 1'b1;
      rsp_idle_on  = 1'b1;
      send_text(KIND_DIM, "18446744073709551615\n");
      send_text(KIND_DIM, "18446744073709551616\n");
      send_text(KIND_DIM, "99999999999999999999\n");
      send_text(KIND_DIM, "4294967296 4294967296 3\n");
      send_text(KIND_DIM, "0 5\n");
      send_text(KIND_DIM, "2 18446744073709551615\n");
      send_text(KIND_COORD, "2 18446744073709551615\n");
      send_text(KIND_COORD, "2 1\n");
      send_text(KIND_DIM, "18446744073709551615 18446744073709551615 2\n");
      send_text(KIND_COORD, "1 1 1\n");
      // a failed dimension line keeps what it stored
      send_text(KIND_DIM, "1 2 3x\n");
      send_text(KIND_COORD, "1 2 3\n");
      repeat (MAX_DIMS + 1) send_text(KIND_DIM, "1 ");
      send_char(KIND_DIM, CHAR_NEWLINE);
      wait_for_results();
   endtask

   // End of input on each kind of line, then the state is back to reset
   task automatic test_end_of_input();
      send_end(KIND_DIM);
      send_text(KIND_DIM, "5 6");
      send_end(KIND_DIM);
      send_text(KIND_DIM, "7");
      send_end(KIND_COORD);
      send_text(KIND_DIM, "5x");
      send_end(KIND_DIM);
      send_text(KIND_DIM, "2 2\n");
      send_text(KIND_COORD, "1 2");
      send_end(KIND_COORD);
      send_text(KIND_COORD, "\n");
      wait_for_results();
   endtask

   // Mostly well-formed dimension and coordinate lines, some noise and early ends
   task automatic test_random_lines();
      int stop_at;
      int lines;
      int r;
      stop_at = sent_items + RANDOM_ITEMS;
      lines   = 0;
      gen_dims.delete();
      while (sent_items < stop_at) begin
         if (lines % 40 == 0) begin
            if ($urandom_range(0, 2) == 0) wait_for_results();
            send_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on  = ($urandom_range(0, 3) != 0);
         end
         lines++;
         r = $urandom_range(0, 99);
         if (r < 20 || (gen_dims.size() == 0 && r < 70)) begin
            send_random_dims(1'b1);
         end else if (r < 80) begin
            send_random_coords();
         end else if (r < 92) begin
            send_noise_line();
         end else begin
            if (r < 96) send_random_dims(1'b0);
            send_end(1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      clear_indexer();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_lines();
      test_overflow();
      test_end_of_input();
      test_random_lines();
      wait_for_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- text_coordinate_line_indexer_core.f -----
sv/tcli_pkg.sv
sv/tcli_mul.sv
sv/text_coordinate_line_indexer_core.sv
tb/sv/text_coordinate_line_indexer_core_test.sv
